### hdl/sfla_pkg.sv
// shared types and constants for the segregated free list allocator
`timescale 1ns / 1ps

package sfla_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned PADDR_W = 4;

   localparam int unsigned SMALL_SHIFT = 3;
   localparam int unsigned MID_SHIFT   = 4;
   localparam int unsigned LARGE_SHIFT = 5;

   localparam logic [SIZE_W-1:0] SMALL_MAX = 16'd8;
   localparam logic [SIZE_W-1:0] MID_MAX   = 16'd16;
   localparam logic [SIZE_W-1:0] LARGE_MAX = 16'd32;

   localparam logic [DATA_W-1:0] SMALL_BASE_RST = 32'd0;
   localparam logic [DATA_W-1:0] MID_BASE_RST   = 32'd4096;
   localparam logic [DATA_W-1:0] LARGE_BASE_RST = 32'd8192;

   localparam logic [1:0] REG_SMALL_BASE = 2'd0;
   localparam logic [1:0] REG_MID_BASE   = 2'd1;
   localparam logic [1:0] REG_LARGE_BASE = 2'd2;

   localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STAT_W-1:0] ST_FREED     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_POOL  = 3'd4;
   localparam logic [STAT_W-1:0] ST_NULL      = 3'd5;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_addr;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic classify;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } dp_status_type;

endpackage

### hdl/segregated_free_list_allocator_core.sv
// top level of the segregated free list pool allocator
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     req_payload (mode, req_size, free_addr)
//   rsp       out        rsp_valid / rsp_ready     rsp_payload (block_addr, status)
//   csr       in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// a beat from idle passes through accept, classify and commit; under steady traffic the
// commit state also accepts the next beat, so a new beat is taken before the last is through;
// the pace is set by the link memory read in classify and the head update in commit
// after reset a clearing pass rebuilds the link memories;
// no request beat is taken until it ends
// commit waits while the result register holds a beat that is not taken
`timescale 1ns / 1ps

module segregated_free_list_allocator_core #(
   parameter int unsigned SMALL_BLOCKS = 512,
   parameter int unsigned MID_BLOCKS   = 256,
   parameter int unsigned LARGE_BLOCKS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sfla_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sfla_pkg::rsp_type             rsp_payload,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sfla_pkg::PADDR_W-1:0]  paddr,
   input  logic [sfla_pkg::DATA_W-1:0]   pwdata,
   output logic [sfla_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import sfla_pkg::*;

   cmd_type           cmd;
   dp_status_type     dp_status;
   logic [DATA_W-1:0] small_base, mid_base, large_base;

   sfla_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .small_base (small_base),
      .mid_base   (mid_base),
      .large_base (large_base)
   );

   sfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   sfla_datapath #(
      .SMALL_BLOCKS (SMALL_BLOCKS),
      .MID_BLOCKS   (MID_BLOCKS),
      .LARGE_BLOCKS (LARGE_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .small_base  (small_base),
      .mid_base    (mid_base),
      .large_base  (large_base)
   );

endmodule

### hdl/sfla_csr.sv
// pool base address registers behind the configuration port
`timescale 1ns / 1ps

module sfla_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfla_pkg::PADDR_W-1:0]     paddr,
   input  logic [sfla_pkg::DATA_W-1:0]      pwdata,
   output logic [sfla_pkg::DATA_W-1:0]      prdata,
   output logic                             pready,
   output logic [sfla_pkg::DATA_W-1:0]      small_base,
   output logic [sfla_pkg::DATA_W-1:0]      mid_base,
   output logic [sfla_pkg::DATA_W-1:0]      large_base
);
   import sfla_pkg::*;

   logic [DATA_W-1:0] small_base_ff, mid_base_ff, large_base_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         small_base_ff <= SMALL_BASE_RST;
         mid_base_ff   <= MID_BASE_RST;
         large_base_ff <= LARGE_BASE_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SMALL_BASE: small_base_ff <= pwdata;
            REG_MID_BASE:   mid_base_ff   <= pwdata;
            REG_LARGE_BASE: large_base_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SMALL_BASE: prdata = small_base_ff;
         REG_MID_BASE:   prdata = mid_base_ff;
         REG_LARGE_BASE: prdata = large_base_ff;
         default:        prdata = '0;
      endcase
   end

   assign small_base = small_base_ff;
   assign mid_base   = mid_base_ff;
   assign large_base = large_base_ff;

endmodule

### hdl/sfla_pool.sv
// one size class: link memory, head register, range check and clearing pass
`timescale 1ns / 1ps

module sfla_pool #(
   parameter int unsigned BLOCKS = 512,
   parameter int unsigned SHIFT  = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sfla_pkg::DATA_W-1:0]   base,
   input  logic [sfla_pkg::ADDR_W-1:0]   free_addr,
   input  logic                          classify,
   input  logic                          pop_en,
   input  logic                          push_en,
   output logic                          cleared,
   output logic                          empty,
   output logic                          hit,
   output logic [sfla_pkg::ADDR_W-1:0]   alloc_addr
);
   import sfla_pkg::*;

   localparam int unsigned IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int unsigned LW = $clog2(BLOCKS + 1);
   localparam logic [LW-1:0] NULL_IDX = LW'(BLOCKS);
   localparam logic [IW-1:0] LAST_IDX = IW'(BLOCKS - 1);
   localparam logic [ADDR_W:0] LAST_OFF = (ADDR_W + 1)'((BLOCKS - 1) << SHIFT);

   logic [LW-1:0] mem [BLOCKS];
   logic [LW-1:0] rd_ff;
   logic [LW-1:0] head_ff, head_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic          clr_busy_ff, clr_busy_in;
   logic          hit_ff;
   logic [IW-1:0] idx_ff;
   logic [ADDR_W:0]   range_end;
   logic [ADDR_W-1:0] offset;
   logic              in_range;

   assign range_end = {1'b0, base} + LAST_OFF;
   assign offset    = free_addr - base;
   assign in_range  = (free_addr >= base) && ({1'b0, free_addr} <= range_end);

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      priority if (pop_en) begin
         head_in = rd_ff;
      end else if (push_en) begin
         head_in = LW'(idx_ff);
      end else begin
         head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         clr_idx_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         head_ff     <= head_in;
         clr_idx_ff  <= clr_idx_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_idx_ff] <= LW'(clr_idx_ff) + LW'(1);
      end else if (push_en) begin
         mem[idx_ff] <= head_ff;
      end
      rd_ff <= mem[head_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (classify) begin
         hit_ff <= in_range;
         idx_ff <= IW'(offset >> SHIFT);
      end
   end

   assign cleared    = !clr_busy_ff;
   assign empty      = (head_ff == NULL_IDX);
   assign hit        = hit_ff;
   assign alloc_addr = base + (ADDR_W'(head_ff) << SHIFT);

endmodule

### hdl/sfla_datapath.sv
// request register, three size class pools and result register
`timescale 1ns / 1ps

module sfla_datapath #(
   parameter int unsigned SMALL_BLOCKS = 512,
   parameter int unsigned MID_BLOCKS   = 256,
   parameter int unsigned LARGE_BLOCKS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfla_pkg::cmd_type             cmd,
   output sfla_pkg::dp_status_type       dp_status,
   input  sfla_pkg::req_type             req_payload,
   output sfla_pkg::rsp_type             rsp_payload,
   input  logic [sfla_pkg::DATA_W-1:0]   small_base,
   input  logic [sfla_pkg::DATA_W-1:0]   mid_base,
   input  logic [sfla_pkg::DATA_W-1:0]   large_base
);
   import sfla_pkg::*;

   req_type req_ff;
   rsp_type rsp_ff, rsp_in;

   logic cleared_s, cleared_m, cleared_l;
   logic empty_s, empty_m, empty_l;
   logic hit_s, hit_m, hit_l;
   logic [ADDR_W-1:0] addr_s, addr_m, addr_l;
   logic sel_s, sel_m, sel_l;
   logic is_alloc, is_null;
   logic pop_s, pop_m, pop_l;
   logic push_s, push_m, push_l;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sel_s    = (req_ff.req_size != '0) && (req_ff.req_size <= SMALL_MAX);
   assign sel_m    = (req_ff.req_size > SMALL_MAX) && (req_ff.req_size <= MID_MAX);
   assign sel_l    = (req_ff.req_size > MID_MAX) && (req_ff.req_size <= LARGE_MAX);
   assign is_alloc = (req_ff.mode == MODE_ALLOC);
   assign is_null  = (req_ff.free_addr == '0);

   assign pop_s  = cmd.commit && is_alloc && sel_s && !empty_s;
   assign pop_m  = cmd.commit && is_alloc && sel_m && !empty_m;
   assign pop_l  = cmd.commit && is_alloc && sel_l && !empty_l;
   assign push_s = cmd.commit && !is_alloc && !is_null && hit_s;
   assign push_m = cmd.commit && !is_alloc && !is_null && !hit_s && hit_m;
   assign push_l = cmd.commit && !is_alloc && !is_null && !hit_s && !hit_m && hit_l;

   always_comb begin
      rsp_in.block_addr = '0;
      rsp_in.status     = ST_NOT_POOL;
      if (is_alloc) begin
         priority if (sel_s) begin
            rsp_in.status     = empty_s ? ST_EMPTY : ST_ALLOCATED;
            rsp_in.block_addr = empty_s ? '0 : addr_s;
         end else if (sel_m) begin
            rsp_in.status     = empty_m ? ST_EMPTY : ST_ALLOCATED;
            rsp_in.block_addr = empty_m ? '0 : addr_m;
         end else if (sel_l) begin
            rsp_in.status     = empty_l ? ST_EMPTY : ST_ALLOCATED;
            rsp_in.block_addr = empty_l ? '0 : addr_l;
         end else begin
            rsp_in.status = ST_BAD_SIZE;
         end
      end else begin
         priority if (is_null) begin
            rsp_in.status = ST_NULL;
         end else if (hit_s || hit_m || hit_l) begin
            rsp_in.status = ST_FREED;
         end else begin
            rsp_in.status = ST_NOT_POOL;
         end
      end
   end

   sfla_pool #(.BLOCKS(SMALL_BLOCKS), .SHIFT(SMALL_SHIFT)) u_small (
      .clock      (clock),
      .reset      (reset),
      .base       (small_base),
      .free_addr  (req_ff.free_addr),
      .classify   (cmd.classify),
      .pop_en     (pop_s),
      .push_en    (push_s),
      .cleared    (cleared_s),
      .empty      (empty_s),
      .hit        (hit_s),
      .alloc_addr (addr_s)
   );

   sfla_pool #(.BLOCKS(MID_BLOCKS), .SHIFT(MID_SHIFT)) u_mid (
      .clock      (clock),
      .reset      (reset),
      .base       (mid_base),
      .free_addr  (req_ff.free_addr),
      .classify   (cmd.classify),
      .pop_en     (pop_m),
      .push_en    (push_m),
      .cleared    (cleared_m),
      .empty      (empty_m),
      .hit        (hit_m),
      .alloc_addr (addr_m)
   );

   sfla_pool #(.BLOCKS(LARGE_BLOCKS), .SHIFT(LARGE_SHIFT)) u_large (
      .clock      (clock),
      .reset      (reset),
      .base       (large_base),
      .free_addr  (req_ff.free_addr),
      .classify   (cmd.classify),
      .pop_en     (pop_l),
      .push_en    (push_l),
      .cleared    (cleared_l),
      .empty      (empty_l),
      .hit        (hit_l),
      .alloc_addr (addr_l)
   );

   assign dp_status.clear_done = cleared_s && cleared_m && cleared_l;
   assign rsp_payload          = rsp_ff;

endmodule

### hdl/sfla_ctrl.sv
// sequencing state machine and handshake control
`timescale 1ns / 1ps

module sfla_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sfla_pkg::cmd_type             cmd,
   input  sfla_pkg::dp_status_type       dp_status
);
   import sfla_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR    = 4'b0001,
      ST_IDLE     = 4'b0010,
      ST_CLASSIFY = 4'b0100,
      ST_COMMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.classify = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               state_in   = req_valid ? ST_CLASSIFY : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result register is occupied");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_capture_next: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_CLASSIFY))
      else $error("captured request not classified next");

   a_classify_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.classify |=> (state_ff == ST_COMMIT))
      else $error("classify not followed by commit");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise result valid");
`endif

endmodule
